### src/tscf_pkg.sv
// Shared types, constants and functions for the telemetry sentence CRC framer.
// No dependencies.
`timescale 1ns / 1ps

package tscf_pkg;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   localparam logic [7:0] ASCII_DOLLAR  = 8'h24;
   localparam logic [7:0] ASCII_STAR    = 8'h2A;
   localparam logic [7:0] ASCII_NEWLINE = 8'h0A;

   typedef logic [3:0] slot_type;

   // positions inside the full sentence sequence of one request
   localparam slot_type SLOT_PREFIX_FIRST = 4'd0;
   localparam slot_type SLOT_PREFIX_LAST  = 4'd3;
   localparam slot_type SLOT_DATA         = 4'd4;
   localparam slot_type SLOT_STAR         = 4'd5;
   localparam slot_type SLOT_HEX3         = 4'd6;
   localparam slot_type SLOT_HEX2         = 4'd7;
   localparam slot_type SLOT_HEX1         = 4'd8;
   localparam slot_type SLOT_HEX0         = 4'd9;
   localparam slot_type SLOT_NEWLINE      = 4'd10;

   typedef struct packed {
      logic        prefix;
      logic        present;
      logic        last;
      logic [7:0]  data;
      logic [15:0] crc;
   } cmd_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
      if (nib < 4'd10) begin
         return 8'h30 + {4'h0, nib};
      end else begin
         return 8'h37 + {4'h0, nib};
      end
   endfunction

endpackage

### src/tscf_front.sv
// Front end: accepts requests, tracks the frame, runs the CRC and builds commands.
// Depends on tscf_pkg.
`timescale 1ns / 1ps

module tscf_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,
   input  logic              req_tuser,
   input  logic              req_tlast,
   output logic              push_valid,
   output tscf_pkg::cmd_type push_cmd,
   input  logic              queue_full
);
   import tscf_pkg::*;

   logic        inside_ff, inside_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] crc_base;
   logic [15:0] crc_next;
   logic        accept;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      crc_base = inside_ff ? crc_ff : CRC_INIT;
      crc_next = req_tuser ? crc_byte(crc_base, req_tdata) : crc_base;

      push_cmd.prefix  = !inside_ff;
      push_cmd.present = req_tuser;
      push_cmd.last    = req_tlast;
      push_cmd.data    = req_tdata;
      push_cmd.crc     = crc_next;
      // drop requests that produce no bytes at all
      push_valid = accept && (!inside_ff || req_tuser || req_tlast);

      inside_in = inside_ff;
      crc_in    = crc_ff;
      if (accept) begin
         if (req_tlast) begin
            inside_in = 1'b0;
            crc_in    = CRC_INIT;
         end else begin
            inside_in = 1'b1;
            crc_in    = crc_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
         crc_ff    <= CRC_INIT;
      end else begin
         inside_ff <= inside_in;
         crc_ff    <= crc_in;
      end
   end

   a_close_frame: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=> (!inside_ff && crc_ff == CRC_INIT))
      else $error("frame not closed after last request");

endmodule

### src/tscf_queue.sv
// Short command queue between front end and back end.
// Depends on tscf_pkg.
`timescale 1ns / 1ps

module tscf_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  tscf_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output tscf_pkg::cmd_type head_cmd
);
   import tscf_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   cmd_type         entry_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign head_cmd = entry_ff[rd_ptr_ff];
   assign do_push  = push_valid && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push_valid && full))
      else $error("push into full queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count out of range");

endmodule

### src/tscf_back.sv
// Back end: walks each command through prefix, data and trailer bytes into the output register.
// Depends on tscf_pkg.
`timescale 1ns / 1ps

module tscf_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              empty,
   input  tscf_pkg::cmd_type head_cmd,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,
   output logic              rsp_tlast
);
   import tscf_pkg::*;

   slot_type   slot_ff, slot_in;
   logic       started_ff, started_in;
   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       last_ff, last_in;

   slot_type   cur_slot;
   slot_type   next_slot;
   logic       is_end;
   logic [7:0] cur_byte;
   logic       emit;

   always_comb begin
      if (started_ff) begin
         cur_slot = slot_ff;
      end else if (head_cmd.prefix) begin
         cur_slot = SLOT_PREFIX_FIRST;
      end else if (head_cmd.present) begin
         cur_slot = SLOT_DATA;
      end else begin
         cur_slot = SLOT_STAR;
      end

      next_slot = cur_slot + 1'b1;
      is_end    = 1'b0;
      cur_byte  = ASCII_DOLLAR;
      case (cur_slot)
         SLOT_PREFIX_LAST: begin
            cur_byte = ASCII_DOLLAR;
            if (head_cmd.present) begin
               next_slot = SLOT_DATA;
            end else begin
               next_slot = SLOT_STAR;
               is_end    = !head_cmd.last;
            end
         end
         SLOT_DATA: begin
            cur_byte = head_cmd.data;
            is_end   = !head_cmd.last;
         end
         SLOT_STAR:    cur_byte = ASCII_STAR;
         SLOT_HEX3:    cur_byte = hex_ascii(head_cmd.crc[15:12]);
         SLOT_HEX2:    cur_byte = hex_ascii(head_cmd.crc[11:8]);
         SLOT_HEX1:    cur_byte = hex_ascii(head_cmd.crc[7:4]);
         SLOT_HEX0:    cur_byte = hex_ascii(head_cmd.crc[3:0]);
         SLOT_NEWLINE: begin
            cur_byte = ASCII_NEWLINE;
            is_end   = 1'b1;
         end
         default:      cur_byte = ASCII_DOLLAR;
      endcase

      emit = !empty && (!valid_ff || rsp_tready);
      pop  = emit && is_end;

      slot_in    = slot_ff;
      started_in = started_ff;
      valid_in   = valid_ff;
      data_in    = data_ff;
      last_in    = last_ff;
      if (rsp_tready) begin
         valid_in = 1'b0;
      end
      if (emit) begin
         valid_in = 1'b1;
         data_in  = cur_byte;
         last_in  = (cur_slot == SLOT_NEWLINE);
         if (is_end) begin
            started_in = 1'b0;
         end else begin
            started_in = 1'b1;
            slot_in    = next_slot;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff    <= SLOT_PREFIX_FIRST;
         started_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         slot_ff    <= slot_in;
         started_ff <= started_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

   a_done_newline: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tdata == ASCII_NEWLINE))
      else $error("sentence end on a byte other than newline");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      started_ff |-> (slot_ff <= SLOT_NEWLINE))
      else $error("sequencer slot out of range");

endmodule

### src/telemetry_sentence_crc_framer.sv
// Top level of the telemetry sentence CRC framer: front end, command queue, back end.
// Depends on tscf_pkg, tscf_front, tscf_queue and tscf_back.
//
//   channel   dir  tdata           tuser          tlast
//   req_      in   message_byte    byte_present   frame_end
//   rsp_      out  out_byte        -              sentence_done
//
// One request is taken per cycle while the command queue has room. The back end sends one
// sentence byte per cycle unless stalled or the queue is empty; a request yields 0 to 11 bytes
// (4 prefix, 1 data, 6 trailer). The CRC update for a byte is done in the cycle it is accepted.
// Reset is synchronous; it empties the queue and starts a new sentence with CRC 0xFFFF.
// A stalled output holds its byte in the output register while the queue keeps filling.
`timescale 1ns / 1ps

module telemetry_sentence_crc_framer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] message_byte
   input  logic       req_tuser,   // [0] byte_present
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast
);
   import tscf_pkg::*;

   logic    push_valid;
   cmd_type push_cmd;
   logic    queue_full;
   logic    queue_empty;
   logic    pop;
   cmd_type head_cmd;

   tscf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .queue_full (queue_full)
   );

   tscf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .empty      (queue_empty),
      .head_cmd   (head_cmd)
   );

   tscf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .empty      (queue_empty),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### sim/telemetry_sentence_crc_framer_tb.sv
// Self-checking testbench for telemetry_sentence_crc_framer: drives message bytes, predicts
// every sentence byte (prefix, echo, CRC trailer) and compares the output stream in order.
// Depends on tscf_pkg and the telemetry_sentence_crc_framer RTL.
`timescale 1ns / 1ps

import tscf_pkg::*;

typedef struct {
   logic [7:0] ch;
   logic       done;
} sentence_char_type;

class sentence_predictor;
   sentence_char_type expected_chars[$];
   logic [15:0]       running_crc;
   logic              in_frame;
   int unsigned       failures;
   string             hex_digits;

   function new();
      running_crc = CRC_INIT;
      in_frame    = 1'b0;
      failures    = 0;
      hex_digits  = "0123456789ABCDEF";
   endfunction

   function void push_char(logic [7:0] ch, logic done);
      sentence_char_type entry;
      entry.ch   = ch;
      entry.done = done;
      expected_chars.push_back(entry);
   endfunction

   // bit-serial CRC-16/CCITT-FALSE, MSB first
   function logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
      logic feedback;
      for (int i = 7; i >= 0; i--) begin
         feedback = crc[15] ^ b[i];
         crc = {crc[14:0], 1'b0} ^ (feedback ? CRC_POLY : 16'h0000);
      end
      return crc;
   endfunction

   function void note_request(logic [7:0] b, logic present, logic last);
      if (!in_frame) begin
         repeat (4) push_char(ASCII_DOLLAR, 1'b0);
         in_frame    = 1'b1;
         running_crc = CRC_INIT;
      end
      if (present) begin
         push_char(b, 1'b0);
         running_crc = crc_step(running_crc, b);
      end
      if (last) begin
         push_char(ASCII_STAR, 1'b0);
         for (int n = 3; n >= 0; n--) begin
            push_char(hex_digits[running_crc[n*4 +: 4]], 1'b0);
         end
         push_char(ASCII_NEWLINE, 1'b1);
         in_frame    = 1'b0;
         running_crc = CRC_INIT;
      end
   endfunction

   function void check_char(logic [7:0] ch, logic done);
      sentence_char_type want;
      if (expected_chars.size() == 0) begin
         $display("%0t: unexpected output byte %h done %b", $time, ch, done);
         failures++;
         return;
      end
      want = expected_chars.pop_front();
      if (ch !== want.ch) begin
         $display("%0t: out_byte expected %h actual %h", $time, want.ch, ch);
         failures++;
      end
      if (done !== want.done) begin
         $display("%0t: sentence_done expected %b actual %b", $time, want.done, done);
         failures++;
      end
   endfunction

   function int pending();
      return expected_chars.size();
   endfunction
endclass

module telemetry_sentence_crc_framer_tb;

   localparam int TOTAL_REQUESTS = 330;
   localparam int CALM_REQUESTS  = 60;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 20;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] message_byte
   logic       req_tuser = 1'b0;    // [0] byte_present
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] out_byte
   logic       rsp_tlast;

   sentence_predictor sentences = new();
   int unsigned       requests_sent = 0;
   int unsigned       quiet_cycles  = 0;
   logic              calm = 1'b0;

   telemetry_sentence_crc_framer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // sample both channels and the watchdog at the same edge the block uses
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sentences.note_request(req_tdata, req_tuser, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            sentences.check_char(rsp_tdata, rsp_tlast);
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAIL telemetry_sentence_crc_framer");
            $finish;
         end
      end
   end

   // output side: random stall bursts, none once the run turns calm
   initial begin
      wait (!reset);
      @(posedge clock);
      forever begin
         if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   end

   // call at a rising edge; returns at the edge the request is taken or after an idle gap
   task automatic send_request(logic [7:0] b, logic present, logic last);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= present;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      requests_sent++;
      calm = (requests_sent >= TOTAL_REQUESTS - CALM_REQUESTS);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // well-formed message with random content, sometimes closed by an empty request
   task automatic send_random_frame();
      int  len;
      bit  close_empty;
      len = ($urandom_range(0, 99) < 10) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      close_empty = (len == 0) || ($urandom_range(0, 2) == 0);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            send_request(8'($urandom), 1'b0, 1'b0);
         end
         send_request(8'($urandom), 1'b1, !close_empty && (i == len - 1));
      end
      if (close_empty) begin
         send_request(8'($urandom), 1'b0, 1'b1);
      end
   endtask

   initial begin
      string check_text;
      check_text = "123456789";

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty message: prefix and trailer with digits FFFF
      send_request(8'hA5, 1'b0, 1'b1);
      // zero byte is data, empty request mid-frame, extreme byte values
      send_request(8'h00, 1'b1, 1'b0);
      send_request(8'hFF, 1'b1, 1'b0);
      send_request(8'h5A, 1'b0, 1'b0);
      send_request(8'h80, 1'b1, 1'b0);
      send_request(8'h01, 1'b1, 1'b1);
      // opening request with no byte emits the prefix alone
      send_request(8'hC3, 1'b0, 1'b0);
      send_request(8'h55, 1'b1, 1'b1);
      // one-byte message, full eleven bytes from a single request
      send_request(8'hAA, 1'b1, 1'b1);
      // standard check string, closed by an empty request: digits 29B1
      for (int i = 0; i < check_text.len(); i++) begin
         send_request(check_text[i], 1'b1, 1'b0);
      end
      send_request(8'h3C, 1'b0, 1'b1);

      while (requests_sent < TOTAL_REQUESTS) begin
         if ($urandom_range(0, 99) < 85) begin
            send_random_frame();
         end else begin
            send_request(8'($urandom), 1'($urandom_range(0, 1)),
                         $urandom_range(0, 3) == 0);
         end
      end
      req_tvalid <= 1'b0;

      while (sentences.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sentences.failures == 0) begin
         $display("PASS telemetry_sentence_crc_framer");
      end else begin
         $display("FAIL telemetry_sentence_crc_framer");
      end
      $finish;
   end

endmodule
